// File: design/dps_pkg.sv
`timescale 1ns / 1ps
// Shared types for the deadline profit scheduler: request and result
// payloads, the stored job entry and the sequencer states. No dependencies.
package dps_pkg;

  localparam int unsigned ValueW    = 20;
  localparam int unsigned DeadlineW = 6;
  localparam int unsigned TotalW    = 26;

  typedef struct packed {
    logic [ValueW-1:0]    job_value;
    logic [DeadlineW-1:0] job_deadline;
    logic                 last_job;
  } dps_in_t;

  typedef struct packed {
    logic [TotalW-1:0] total_value;
    logic              overflow;
  } dps_out_t;

  typedef struct packed {
    logic                 served;
    logic [DeadlineW-1:0] deadline;
    logic [ValueW-1:0]    value;
  } dps_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAXD,
    ST_SCAN,
    ST_SERVE,
    ST_DONE
  } dps_state_e;

endpackage

// File: design/dps_job_store.sv
`timescale 1ns / 1ps
// Job store: one write port and one registered read port over the job entries.
// Depends on dps_pkg for the entry type.
module dps_job_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  dps_pkg::dps_entry_t wdata_i,
  input  logic                re_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output dps_pkg::dps_entry_t rdata_o
);
  import dps_pkg::*;

  dps_entry_t mem_q [DEPTH];
  dps_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/dps_seq.sv
`timescale 1ns / 1ps
// Sequencer: loads jobs, finds the top deadline, then scans the store once per
// slot with one shared comparator and a saturating accumulator. Uses dps_pkg.
module dps_seq #(
  parameter int unsigned MAX_JOBS  = 64,
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned IDX_W     = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  dps_pkg::dps_in_t    in_req_i,
  output logic                busy_o,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output dps_pkg::dps_out_t   res_o,
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output dps_pkg::dps_entry_t mem_wdata_o,
  output logic                mem_re_o,
  output logic [IDX_W-1:0]    mem_raddr_o,
  input  dps_pkg::dps_entry_t mem_rdata_i
);
  import dps_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned SlotW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CmpW  = (SlotW > DeadlineW) ? SlotW : DeadlineW;
  localparam logic [CmpW-1:0]  LastSlot = CmpW'(MAX_SLOTS - 1);
  localparam logic [CntW-1:0]  JobsMax  = CntW'(MAX_JOBS);
  localparam logic [TotalW-1:0] TotalMax = '1;

  dps_state_e state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 dropped_q, dropped_d;
  logic [CntW-1:0]      issue_q, issue_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [DeadlineW-1:0] top_q, top_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  dps_entry_t           best_q, best_d;
  logic [TotalW-1:0]    total_q, total_d;

  logic              issue_en;
  logic              scan_end;
  logic [ValueW-1:0] cmp_a, cmp_b;
  logic              cmp_gt;
  logic              eligible;
  logic [TotalW:0]   sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    top_q      <= top_d;
    slot_q     <= slot_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    total_q    <= total_d;
  end

  assign issue_en = ((state_q == ST_MAXD) || (state_q == ST_SCAN)) && (issue_q < count_q);
  assign scan_end = (issue_q >= count_q) && !rd_vld_q;

  always_comb begin
    if (state_q == ST_MAXD) begin
      cmp_a = {{(ValueW-DeadlineW){1'b0}}, mem_rdata_i.deadline};
      cmp_b = {{(ValueW-DeadlineW){1'b0}}, top_q};
    end else begin
      cmp_a = mem_rdata_i.value;
      cmp_b = best_q.value;
    end
  end

  assign cmp_gt   = cmp_a > cmp_b;
  assign eligible = !mem_rdata_i.served &&
                    (CmpW'(mem_rdata_i.deadline) >= CmpW'(slot_q));
  assign sum      = {1'b0, total_q} + {{(TotalW+1-ValueW){1'b0}}, best_q.value};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    issue_d     = issue_q;
    rd_vld_d    = issue_en;
    rd_idx_d    = issue_q[IDX_W-1:0];
    top_d       = top_q;
    slot_d      = slot_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    total_d     = total_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[IDX_W-1:0];
    mem_wdata_o = '{served: 1'b0, deadline: in_req_i.job_deadline,
                    value: in_req_i.job_value};
    res_valid_o = 1'b0;
    if (issue_en) begin
      issue_d = issue_q + 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          if (count_q < JobsMax) begin
            mem_we_o = 1'b1;
            count_d  = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_req_i.last_job) begin
            state_d = ST_MAXD;
            issue_d = '0;
            top_d   = '0;
            total_d = '0;
          end
        end
      end
      ST_MAXD: begin
        if (rd_vld_q && cmp_gt) begin
          top_d = mem_rdata_i.deadline;
        end
        if (scan_end) begin
          if (CmpW'(top_q) > LastSlot) begin
            slot_d = SlotW'(MAX_SLOTS - 1);
          end else begin
            slot_d = SlotW'(top_q);
          end
          state_d = ST_SCAN;
          issue_d = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && eligible && (!found_q || cmp_gt)) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_d     = mem_rdata_i;
        end
        if (scan_end) begin
          state_d = ST_SERVE;
        end
      end
      ST_SERVE: begin
        if (found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = best_idx_q;
          mem_wdata_o = '{served: 1'b1, deadline: best_q.deadline, value: best_q.value};
          total_d     = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
        end
        if (slot_q == '0) begin
          state_d = ST_DONE;
        end else begin
          slot_d  = slot_q - 1'b1;
          state_d = ST_SCAN;
          issue_d = '0;
          found_d = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
          count_d     = '0;
          dropped_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign mem_re_o    = issue_en;
  assign mem_raddr_o = issue_q[IDX_W-1:0];
  assign res_o       = '{total_value: total_q, overflow: dropped_q};

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("store written and read in the same cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= JobsMax)
    else $error("job count beyond store depth");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_MAXD || state_q == ST_SCAN))
    else $error("read data pending outside a scan");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == ST_IDLE && count_q == '0 && !dropped_q))
    else $error("batch not cleared after result");

  a_serve_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SERVE && found_q) |-> (CntW'(best_idx_q) < count_q))
    else $error("served job outside stored range");
`endif

endmodule

// File: design/deadline_profit_scheduler_unit.sv
`timescale 1ns / 1ps
// Deadline profit scheduler top level. Depends on dps_pkg, dps_job_store, dps_seq.
// Each request without last_job is taken while the unit is idle. A request with last_job
// starts the walk: a search for the top deadline over the N stored jobs, then one scan of
// the store per slot, start slot down to 0; the comparator and the store read port
// are shared by every scan. Result registered at the output. Reset clears the batch.
module deadline_profit_scheduler_unit #(
  parameter int unsigned MAX_JOBS  = 64,
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dps_pkg::dps_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dps_pkg::dps_out_t out_req_o
);
  import dps_pkg::*;

  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  logic       busy;
  logic       in_fire;
  logic       out_free;
  logic       res_valid;
  dps_out_t   res;
  logic       mem_we;
  logic [IdxW-1:0] mem_waddr;
  dps_entry_t mem_wdata;
  logic       mem_re;
  logic [IdxW-1:0] mem_raddr;
  dps_entry_t mem_rdata;
  logic       out_valid_q;
  dps_out_t   out_req_q;

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  dps_seq #(
    .MAX_JOBS (MAX_JOBS),
    .MAX_SLOTS(MAX_SLOTS),
    .IDX_W    (IdxW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_req_i   (in_req_i),
    .busy_o     (busy),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  dps_job_store #(
    .DEPTH(MAX_JOBS),
    .IDX_W(IdxW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

// File: sim/deadline_profit_scheduler_unit_test.sv
`timescale 1ns / 1ps
// Self-checking test of deadline_profit_scheduler_unit: job batches in, one scheduled
// total per batch out, checked against a greedy slot walk kept in the test.
// Depends on dps_pkg and the unit RTL.
module deadline_profit_scheduler_unit_test;
  import dps_pkg::*;

  localparam int unsigned MaxJobs       = 64;
  localparam int unsigned MaxSlots      = 64;
  localparam int unsigned TotalMax      = (1 << TotalW) - 1;
  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned RandomItems   = 500;
  localparam int unsigned HoldOffCycles = 2000;
  localparam int unsigned WatchdogLimit = 40000;
  localparam int unsigned DrainCycles   = 50;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  dps_in_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  dps_out_t out_req_o;

  dps_in_t                 pending_requests[$];
  dps_out_t                expected_results[$];
  logic [ValueW-1:0]       stored_values[$];
  logic [DeadlineW-1:0]    stored_deadlines[$];
  logic                    batch_dropped = 1'b0;
  logic                    calm = 1'b0;
  int unsigned             gap_left;
  int unsigned             stall_left;
  int unsigned             hold_left;
  int unsigned             idle_cycles;
  int unsigned             request_count;
  int unsigned             batch_count;
  int unsigned             dropped_batches;
  int unsigned             results_seen;
  int unsigned             error_count;

  deadline_profit_scheduler_unit #(
    .MAX_JOBS (MaxJobs),
    .MAX_SLOTS(MaxSlots)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 3) return '1;
    if (r < 6) return ValueW'($urandom_range(0, 15));
    return ValueW'($urandom_range(0, (1 << ValueW) - 1));
  endfunction

  function automatic logic [DeadlineW-1:0] pick_deadline();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return DeadlineW'($urandom_range(0, 7));
    if (r < 8) return DeadlineW'($urandom_range(0, (1 << DeadlineW) - 1));
    if (r < 9) return '1;
    return '0;
  endfunction

  function automatic void queue_job(logic [ValueW-1:0] value, logic [DeadlineW-1:0] deadline,
                                    logic last);
    dps_in_t req;
    req.job_value    = value;
    req.job_deadline = deadline;
    req.last_job     = last;
    pending_requests.push_back(req);
  endfunction

  // Greedy walk: from the top deadline down to slot 0, take the best unserved eligible job.
  function automatic logic [TotalW-1:0] schedule_total();
    logic [MaxJobs-1:0] taken;
    int unsigned        top;
    int unsigned        total;
    int                 best;
    taken = '0;
    top   = 0;
    total = 0;
    foreach (stored_deadlines[k])
      if (32'(stored_deadlines[k]) > top) top = 32'(stored_deadlines[k]);
    if (top > MaxSlots - 1) top = MaxSlots - 1;
    for (int slot = int'(top); slot >= 0; slot--) begin
      best = -1;
      foreach (stored_values[k])
        if (!taken[k] && int'(stored_deadlines[k]) >= slot &&
            (best < 0 || stored_values[k] > stored_values[best])) best = k;
      if (best >= 0) begin
        taken[best] = 1'b1;
        total += 32'(stored_values[best]);
        if (total > TotalMax) total = TotalMax;
      end
    end
    return total[TotalW-1:0];
  endfunction

  function automatic void take_request(dps_in_t req);
    dps_out_t predicted;
    request_count++;
    if (stored_values.size() < MaxJobs) begin
      stored_values.push_back(req.job_value);
      stored_deadlines.push_back(req.job_deadline);
    end else begin
      batch_dropped = 1'b1;
    end
    if (req.last_job) begin
      predicted.total_value = schedule_total();
      predicted.overflow    = batch_dropped;
      expected_results.push_back(predicted);
      batch_count++;
      if (batch_dropped) dropped_batches++;
      stored_values.delete();
      stored_deadlines.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) take_request(in_req_i);
      if (in_valid_i && in_stall_o) begin
        // hold the stalled request
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_requests.size() > 0) begin
        in_valid_i <= 1'b1;
        in_req_i   <= pending_requests[0];
        if (pending_requests[0].last_job) calm <= ($urandom_range(0, 3) == 0);
        void'(pending_requests.pop_front());
        gap_left   <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result total_value=%0d overflow=%0b", $time,
                   out_req_o.total_value, out_req_o.overflow);
        end else begin
          if (out_req_o.total_value !== expected_results[0].total_value) begin
            error_count++;
            $display("%0t: total_value expected %0d actual %0d", $time,
                     expected_results[0].total_value, out_req_o.total_value);
          end
          if (out_req_o.overflow !== expected_results[0].overflow) begin
            error_count++;
            $display("%0t: overflow expected %0b actual %0b", $time,
                     expected_results[0].overflow, out_req_o.overflow);
          end
          void'(expected_results.pop_front());
        end
      end
      if (results_seen == 5 && out_valid_o && !out_stall_i) begin
        out_stall_i <= 1'b1;
        hold_left   <= HoldOffCycles;
      end else if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned batch_no;
    int unsigned batch_len;
    int unsigned queued;
    logic        heavy;
    queue_job('1, '1, 1'b1);
    queue_job('0, '0, 1'b1);
    queue_job(20'd5, 6'd0, 1'b0);
    queue_job(20'd5, 6'd0, 1'b0);
    queue_job(20'd5, 6'd1, 1'b1);
    queue_job(20'd100, 6'd2, 1'b0);
    queue_job(20'd200, 6'd0, 1'b0);
    queue_job(20'd50, 6'd2, 1'b0);
    queue_job(20'd300, 6'd1, 1'b1);
    queue_job(20'hAAAAA, 6'h2A, 1'b0);
    queue_job(20'h55555, 6'h15, 1'b1);
    queue_job('1, 6'd0, 1'b0);
    queue_job('1, 6'd0, 1'b0);
    queue_job(20'd1, '1, 1'b1);
    batch_no = 0;
    queued   = 0;
    while (queued < RandomItems) begin
      heavy = 1'b0;
      unique case (batch_no)
        6: begin
          batch_len = MaxJobs;
          heavy     = 1'b1;
        end
        18: batch_len = MaxJobs + 1 + $urandom_range(0, 5);
        30: batch_len = MaxJobs + 6;
        default: batch_len = $urandom_range(1, 8);
      endcase
      for (int j = 0; j < batch_len; j++)
        if (heavy) queue_job('1, '1, j == batch_len - 1);
        else queue_job(pick_value(), pick_deadline(), j == batch_len - 1);
      queued += batch_len;
      batch_no++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests in %0d batches, %0d of them over capacity; %0d results checked.",
             request_count, batch_count, dropped_batches, results_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
design/dps_pkg.sv
design/dps_job_store.sv
design/dps_seq.sv
design/deadline_profit_scheduler_unit.sv
sim/deadline_profit_scheduler_unit_test.sv
